[hw/rtl/narug_pkg.sv]
// shared types and constants of the nonce anti-replay unlock gate
`default_nettype none
package narug_pkg;

	localparam int unsigned NONCE_W    = 32;
	localparam int unsigned TS_W       = 32;
	localparam int unsigned CODE_W     = 8;
	localparam int unsigned REASON_W   = 3;
	localparam int unsigned ATTEMPT_W  = 16;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE_CMD     = 1'd1;

	localparam logic [NONCE_W-1:0]   WINDOW_RESET     = 32'd100;
	localparam logic [CODE_W-1:0]    NONE_CMD_RESET   = 8'd0;

	localparam logic [REASON_W-1:0]  REASON_OK        = 3'd0;
	localparam logic [REASON_W-1:0]  REASON_NO_CMD    = 3'd1;
	localparam logic [REASON_W-1:0]  REASON_ZERO_TS   = 3'd2;
	localparam logic [REASON_W-1:0]  REASON_WINDOW    = 3'd3;
	localparam logic [REASON_W-1:0]  REASON_REPLAY    = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_OUT
	} narug_state_t;

	typedef struct packed {
		logic                 command_valid;
		logic                 unlock_allowed;
		logic [REASON_W-1:0]  reject_reason;
		logic [ATTEMPT_W-1:0] invalid_attempts;
	} narug_result_t;

endpackage
`default_nettype wire

[hw/rtl/narug_ram.sv]
// generic simple dual-port ram with registered read
`default_nettype none
module narug_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[hw/rtl/narug_ctrl.sv]
// check sequencer: code, timestamp and window checks, history scan and state update
`default_nettype none
module narug_ctrl #(
	parameter int unsigned HISTORY_DEPTH = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             cmd,
	input  wire logic [narug_pkg::CODE_W-1:0]     cmd_code,
	input  wire logic [narug_pkg::TS_W-1:0]       cmd_stamp,
	input  wire logic [narug_pkg::NONCE_W-1:0]    nonce,
	input  wire logic                             ack_received,
	input  wire logic [narug_pkg::NONCE_W-1:0]    window_size,
	input  wire logic [narug_pkg::CODE_W-1:0]     none_command_code,
	output logic                                  res_valid,
	input  wire logic                             res_take,
	output narug_pkg::narug_result_t              res
);
	import narug_pkg::*;

	localparam int unsigned IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(HISTORY_DEPTH);

	narug_state_t state_q, state_d;

	logic                 cmd_q;
	logic [CODE_W-1:0]    code_q;
	logic [TS_W-1:0]      ts_q;
	logic [NONCE_W-1:0]   nonce_q;
	logic                 ack_q;

	logic [NONCE_W-1:0]   last_nonce_q;
	logic [IDX_W-1:0]     wr_idx_q;
	logic [CNT_W-1:0]     fill_q;
	logic [ATTEMPT_W-1:0] fail_q;
	logic [IDX_W-1:0]     rd_idx_q;
	narug_result_t        res_q;

	logic                 accept;
	logic [REASON_W-1:0]  early_reason;
	logic                 hit;
	logic                 last_rd;
	logic                 finish;
	logic                 scan_go;
	logic [REASON_W-1:0]  fin_reason;
	logic                 commit;
	logic [ATTEMPT_W-1:0] fail_d;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_raddr;
	logic [NONCE_W-1:0]   ram_rdata;

	narug_ram #(
		.WIDTH (NONCE_W),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_idx_q),
		.wdata (nonce_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign accept  = in_valid && !in_stall;
	assign hit     = (ram_rdata == nonce_q);
	assign last_rd = (rd_idx_q == IDX_W'(fill_q - CNT_W'(1)));

	always_comb begin
		priority if (code_q == none_command_code) begin
			early_reason = REASON_NO_CMD;
		end else if (ts_q == '0) begin
			early_reason = REASON_ZERO_TS;
		end else if ((nonce_q <= last_nonce_q) || ((nonce_q - last_nonce_q) > window_size)) begin
			early_reason = REASON_WINDOW;
		end else begin
			early_reason = REASON_OK;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (finish) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (finish) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		finish     = 1'b0;
		scan_go    = 1'b0;
		fin_reason = REASON_OK;
		ram_raddr  = IDX_W'(rd_idx_q + IDX_W'(1));
		in_stall   = 1'b1;
		res_valid  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_CHECK: begin
				ram_raddr  = '0;
				fin_reason = early_reason;
				if (early_reason != REASON_OK || fill_q == '0) begin
					finish = 1'b1;
				end else begin
					scan_go = 1'b1;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					finish     = 1'b1;
					fin_reason = REASON_REPLAY;
				end else if (last_rd) begin
					finish     = 1'b1;
				end
			end
			ST_OUT: begin
				res_valid = 1'b1;
			end
			default: ;
		endcase
	end

	assign commit = finish && (fin_reason == REASON_OK);
	assign ram_we = commit;
	assign fail_d = (cmd_q && fin_reason != REASON_OK && fail_q != '1)
		? ATTEMPT_W'(fail_q + ATTEMPT_W'(1)) : fail_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			last_nonce_q <= '0;
			wr_idx_q     <= '0;
			fill_q       <= '0;
			fail_q       <= '0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				fail_q <= fail_d;
			end
			if (commit) begin
				last_nonce_q <= nonce_q;
				wr_idx_q     <= (wr_idx_q == LAST_IDX) ? '0 : IDX_W'(wr_idx_q + IDX_W'(1));
				if (fill_q != FULL_CNT) begin
					fill_q <= CNT_W'(fill_q + CNT_W'(1));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd;
			code_q  <= cmd_code;
			ts_q    <= cmd_stamp;
			nonce_q <= nonce;
			ack_q   <= ack_received;
		end
		if (scan_go) begin
			rd_idx_q <= '0;
		end else if (state_q == ST_SCAN) begin
			rd_idx_q <= ram_raddr;
		end
		if (finish) begin
			res_q.command_valid    <= (fin_reason == REASON_OK);
			res_q.unlock_allowed   <= cmd_q && ack_q && (fin_reason == REASON_OK);
			res_q.reject_reason    <= fin_reason;
			res_q.invalid_attempts <= fail_d;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("history fill count above depth");

	a_commit_last: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> last_nonce_q == $past(nonce_q))
		else $error("last nonce not updated on history write");

	a_replay_needs_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && fin_reason == REASON_REPLAY) |-> fill_q != '0)
		else $error("replay reported with empty history");

	a_fail_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		fail_q >= $past(fail_q))
		else $error("failed attempt counter decreased");

endmodule
`default_nettype wire

[hw/rtl/nonce_anti_replay_unlock_gate.sv]
// top level: configuration registers, check sequencer and output register
//
// Checks remote command words against an anti-replay window and a ring of the
// last HISTORY_DEPTH accepted nonces held in a one-port-read ram. One word is
// processed at a time: a word rejected on code, timestamp or window, or arriving
// while the history is empty, goes from the check state to the output state;
// otherwise the history is read one entry per cycle until a match or the last
// filled entry. The result sits in an output register, so the next word is
// taken while a result still waits downstream. Configuration is to be written
// only while no word is in flight; the user is bound, the block does not enforce it.
`default_nettype none
module nonce_anti_replay_unlock_gate #(
	parameter int unsigned HISTORY_DEPTH = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [narug_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [narug_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              cmd,
	input  wire logic [narug_pkg::CODE_W-1:0]      cmd_code,
	input  wire logic [narug_pkg::TS_W-1:0]        cmd_stamp,
	input  wire logic [narug_pkg::NONCE_W-1:0]     nonce,
	input  wire logic                              ack_received,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   command_valid,
	output logic                                   unlock_allowed,
	output logic [narug_pkg::REASON_W-1:0]         reject_reason,
	output logic [narug_pkg::ATTEMPT_W-1:0]        invalid_attempts
);
	import narug_pkg::*;

	logic [NONCE_W-1:0] window_size_q;
	logic [CODE_W-1:0]  none_cmd_q;
	logic               res_valid;
	logic               res_take;
	narug_result_t      res;
	logic               out_valid_q;
	narug_result_t      out_q;

	narug_ctrl #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.cmd               (cmd),
		.cmd_code          (cmd_code),
		.cmd_stamp         (cmd_stamp),
		.nonce             (nonce),
		.ack_received      (ack_received),
		.window_size       (window_size_q),
		.none_command_code (none_cmd_q),
		.res_valid         (res_valid),
		.res_take          (res_take),
		.res               (res)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_RESET;
			none_cmd_q    <= NONE_CMD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_WINDOW_SIZE: window_size_q <= cfg_wdata;
				CFG_NONE_CMD:    none_cmd_q    <= cfg_wdata[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// output word register
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign command_valid    = out_q.command_valid;
	assign unlock_allowed   = out_q.unlock_allowed;
	assign reject_reason    = out_q.reject_reason;
	assign invalid_attempts = out_q.invalid_attempts;

endmodule
`default_nettype wire

[sim/tb.sv]
// self-checking testbench of the nonce anti-replay unlock gate: directed table, random words, predictor
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import narug_pkg::*;

	localparam int unsigned HIST_DEPTH = 8;
	localparam int unsigned SIM_LIMIT  = 5_000_000;
	localparam logic [31:0] STEP_CAP   = 32'h0010_0000;
	localparam int unsigned PHASE_N    = 7;
	localparam int unsigned PHASE_LEN  = 172;
	localparam int unsigned DIR_N      = 22;

	typedef struct packed {
		logic                cmd;
		logic [CODE_W-1:0]   code;
		logic [TS_W-1:0]     ts;
		logic [NONCE_W-1:0]  nonce;
		logic                ack;
	} word_t;

	typedef struct packed {
		logic                set_cfg;
		logic [NONCE_W-1:0]  win;
		logic [CODE_W-1:0]   none_code;
		word_t               w;
		logic                chk;
		narug_result_t       r;
	} dir_row_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY
	} stall_mode_t;

	localparam dir_row_t DIR_TAB [DIR_N] = '{
		'{1'b0, 32'd0, 8'h00, '{1'b1, 8'h00, 32'd1, 32'd1, 1'b1},
			1'b1, '{1'b0, 1'b0, REASON_NO_CMD, 16'd1}},
		'{1'b0, 32'd0, 8'h00, '{1'b1, 8'h5A, 32'd0, 32'd1, 1'b1},
			1'b1, '{1'b0, 1'b0, REASON_ZERO_TS, 16'd2}},
		'{1'b0, 32'd0, 8'h00, '{1'b1, 8'h5A, 32'd1, 32'd0, 1'b1},
			1'b1, '{1'b0, 1'b0, REASON_WINDOW, 16'd3}},
		'{1'b0, 32'd0, 8'h00, '{1'b1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
			1'b1, '{1'b0, 1'b0, REASON_WINDOW, 16'd4}},
		'{1'b0, 32'd0, 8'h00, '{1'b1, 8'h01, 32'd1, 32'd101, 1'b1},
			1'b1, '{1'b0, 1'b0, REASON_WINDOW, 16'd5}},
		'{1'b0, 32'd0, 8'h00, '{1'b1, 8'hFF, 32'hFFFF_FFFF, 32'd100, 1'b1},
			1'b1, '{1'b1, 1'b1, REASON_OK, 16'd5}},
		'{1'b0, 32'd0, 8'h00, '{1'b1, 8'h01, 32'd7, 32'd100, 1'b0},
			1'b1, '{1'b0, 1'b0, REASON_WINDOW, 16'd6}},
		'{1'b0, 32'd0, 8'h00, '{1'b0, 8'h01, 32'd5, 32'd101, 1'b1},
			1'b1, '{1'b1, 1'b0, REASON_OK, 16'd6}},
		'{1'b0, 32'd0, 8'h00, '{1'b1, 8'h02, 32'd9, 32'd150, 1'b0},
			1'b1, '{1'b1, 1'b0, REASON_OK, 16'd6}},
		'{1'b0, 32'd0, 8'h00, '{1'b0, 8'h00, 32'd9, 32'd151, 1'b1},
			1'b1, '{1'b0, 1'b0, REASON_NO_CMD, 16'd6}},
		'{1'b0, 32'd0, 8'h00, '{1'b1, 8'h03, 32'd0, 32'd151, 1'b1},
			1'b1, '{1'b0, 1'b0, REASON_ZERO_TS, 16'd7}},
		'{1'b0, 32'd0, 8'h00, '{1'b1, 8'h03, 32'd3, 32'd100, 1'b1},
			1'b1, '{1'b0, 1'b0, REASON_WINDOW, 16'd8}},
		'{1'b0, 32'd0, 8'h00, '{1'b1, 8'h04, 32'd1, 32'd151, 1'b1},
			1'b1, '{1'b1, 1'b1, REASON_OK, 16'd8}},
		'{1'b1, 32'd0, 8'hFF, '{1'b1, 8'h04, 32'd1, 32'd152, 1'b1},
			1'b1, '{1'b0, 1'b0, REASON_WINDOW, 16'd9}},
		'{1'b0, 32'd0, 8'h00, '{1'b1, 8'h00, 32'd1, 32'd152, 1'b1},
			1'b1, '{1'b0, 1'b0, REASON_WINDOW, 16'd10}},
		'{1'b0, 32'd0, 8'h00, '{1'b1, 8'hFF, 32'd1, 32'd152, 1'b1},
			1'b1, '{1'b0, 1'b0, REASON_NO_CMD, 16'd11}},
		'{1'b1, 32'd1, 8'h80, '{1'b1, 8'h00, 32'd1, 32'd152, 1'b1},
			1'b1, '{1'b1, 1'b1, REASON_OK, 16'd11}},
		'{1'b0, 32'd0, 8'h00, '{1'b1, 8'h80, 32'd1, 32'd153, 1'b1},
			1'b1, '{1'b0, 1'b0, REASON_NO_CMD, 16'd12}},
		'{1'b0, 32'd0, 8'h00, '{1'b0, 8'h7F, 32'd1, 32'd154, 1'b1},
			1'b1, '{1'b0, 1'b0, REASON_WINDOW, 16'd12}},
		'{1'b1, 32'd100, 8'h00, '{1'b1, 8'h01, 32'd1, 32'd252, 1'b1},
			1'b1, '{1'b1, 1'b1, REASON_OK, 16'd12}},
		'{1'b0, 32'd0, 8'h00, '{1'b1, 8'hA5, 32'h8000_0000, 32'd253, 1'b1},
			1'b0, '0},
		'{1'b0, 32'd0, 8'h00, '{1'b0, 8'h7E, 32'h0000_FFFF, 32'd300, 1'b0},
			1'b0, '0}
	};

	localparam logic [NONCE_W-1:0] PHASE_WIN [PHASE_N] = '{
		32'd100, 32'd1, 32'd7, 32'd5000, 32'h0010_0000, 32'hFFFF_FFFF, 32'd0
	};

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_idx;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	logic                   in_valid;
	logic                   in_stall;
	logic                   cmd;
	logic [CODE_W-1:0]      cmd_code;
	logic [TS_W-1:0]        cmd_stamp;
	logic [NONCE_W-1:0]     nonce;
	logic                   ack_received;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   command_valid;
	logic                   unlock_allowed;
	logic [REASON_W-1:0]    reject_reason;
	logic [ATTEMPT_W-1:0]   invalid_attempts;

	nonce_anti_replay_unlock_gate dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.cmd              (cmd),
		.cmd_code         (cmd_code),
		.cmd_stamp        (cmd_stamp),
		.nonce            (nonce),
		.ack_received     (ack_received),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.command_valid    (command_valid),
		.unlock_allowed   (unlock_allowed),
		.reject_reason    (reject_reason),
		.invalid_attempts (invalid_attempts)
	);

	// predicted gate state
	logic [NONCE_W-1:0]    cur_window;
	logic [CODE_W-1:0]     cur_none;
	logic [NONCE_W-1:0]    last_nonce;
	logic [NONCE_W-1:0]    nonce_hist [HIST_DEPTH];
	int unsigned           hist_wr;
	logic [ATTEMPT_W-1:0]  fail_cnt;

	narug_result_t         pending_results [$];
	int unsigned           errors = 0;
	int unsigned           burst_left;
	logic                  sender_idle;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic narug_result_t gate_predict(input word_t w);
		narug_result_t   r;
		logic [2:0]      why;
		logic            hit;
		int unsigned     i;
		r = '0;
		if (w.code == cur_none) begin
			why = REASON_NO_CMD;
		end else if (w.ts == '0) begin
			why = REASON_ZERO_TS;
		end else if (w.nonce <= last_nonce || (w.nonce - last_nonce) > cur_window) begin
			why = REASON_WINDOW;
		end else begin
			hit = 1'b0;
			for (i = 0; i < HIST_DEPTH; i++) begin
				if (nonce_hist[i] == w.nonce)
					hit = 1'b1;
			end
			if (hit) begin
				why = REASON_REPLAY;
			end else begin
				why = REASON_OK;
				last_nonce = w.nonce;
				nonce_hist[hist_wr] = w.nonce;
				hist_wr = (hist_wr + 1) % HIST_DEPTH;
			end
		end
		r.command_valid = (why == REASON_OK);
		if (w.cmd) begin
			if (!r.command_valid) begin
				if (fail_cnt != '1)
					fail_cnt = fail_cnt + 1'b1;
			end else if (w.ack) begin
				r.unlock_allowed = 1'b1;
			end
		end
		r.reject_reason = why;
		r.invalid_attempts = fail_cnt;
		return r;
	endfunction

	function automatic word_t rand_word();
		word_t             w;
		int unsigned       kind;
		int unsigned       sel;
		logic [NONCE_W-1:0] span;
		logic [NONCE_W-1:0] step;
		w.cmd = 1'($urandom);
		w.ack = 1'($urandom);
		w.code = CODE_W'($urandom);
		w.ts = $urandom;
		w.nonce = $urandom;
		kind = $urandom_range(0, 99);
		if (kind < 90) begin
			while (w.code == cur_none)
				w.code = CODE_W'($urandom);
			if (w.ts == '0)
				w.ts = 32'd1;
		end
		if (kind < 75) begin
			span = (cur_window > STEP_CAP) ? STEP_CAP : cur_window;
			step = (span == '0) ? 32'd1 : $urandom_range(1, span);
			w.nonce = last_nonce + step;
			if (w.nonce <= last_nonce)
				w.nonce = $urandom;
		end else if (kind < 85) begin
			// replays and near misses around the window
			sel = $urandom_range(0, 2);
			if (sel == 0)
				w.nonce = last_nonce;
			else if (sel == 1)
				w.nonce = nonce_hist[$urandom_range(0, HIST_DEPTH - 1)];
			else
				w.nonce = last_nonce + cur_window + 1;
		end else if (kind < 90) begin
			w.ts = '0;
		end else if (kind < 94) begin
			w.code = cur_none;
		end
		return w;
	endfunction

	task automatic send_word(input word_t w, input logic chk, input narug_result_t typed);
		narug_result_t r;
		in_valid <= 1'b1;
		cmd <= w.cmd;
		cmd_code <= w.code;
		cmd_stamp <= w.ts;
		nonce <= w.nonce;
		ack_received <= w.ack;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = gate_predict(w);
		pending_results.push_back(chk ? typed : r);
	endtask

	task automatic pace();
		int unsigned gap;
		if (burst_left == 0) begin
			gap = (!sender_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [NONCE_W-1:0] win, input logic [CODE_W-1:0] code);
		logic [CFG_DATA_W-1:0] pad;
		pad = $urandom;
		cfg_we <= 1'b1;
		cfg_idx <= CFG_WINDOW_SIZE;
		cfg_wdata <= win;
		@(posedge clk);
		cur_window = win;
		cfg_idx <= CFG_NONE_CMD;
		cfg_wdata <= {pad[CFG_DATA_W-1:CODE_W], code};
		@(posedge clk);
		cur_none = code;
		cfg_we <= 1'b0;
	endtask

	// receiver stall pattern
	stall_mode_t stall_mode = STALL_NONE;
	int unsigned stall_mode_left = 0;
	int unsigned stall_run = 0;
	always @(posedge clk) begin
		logic pick;
		if (stall_mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 2));
			stall_mode_left = $urandom_range(16, 256);
		end else begin
			stall_mode_left--;
		end
		case (stall_mode)
			STALL_LIGHT: pick = ($urandom_range(0, 3) == 0);
			STALL_HEAVY: pick = ($urandom_range(0, 3) != 0);
			default:     pick = 1'b0;
		endcase
		if (pick && stall_run < 6) begin
			out_stall <= 1'b1;
			stall_run++;
		end else begin
			out_stall <= 1'b0;
			stall_run = 0;
		end
	end

	always @(posedge clk) begin
		narug_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (command_valid !== want.command_valid) begin
					$error("command_valid: expected %0d, got %0d",
						want.command_valid, command_valid);
					errors++;
				end
				if (unlock_allowed !== want.unlock_allowed) begin
					$error("unlock_allowed: expected %0d, got %0d",
						want.unlock_allowed, unlock_allowed);
					errors++;
				end
				if (reject_reason !== want.reject_reason) begin
					$error("reject_reason: expected %0d, got %0d",
						want.reject_reason, reject_reason);
					errors++;
				end
				if (invalid_attempts !== want.invalid_attempts) begin
					$error("invalid_attempts: expected %0d, got %0d",
						want.invalid_attempts, invalid_attempts);
					errors++;
				end
			end
		end
	end

	int unsigned cycles = 0;
	initial begin
		while (cycles < SIM_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int unsigned    i;
		int unsigned    p;
		int unsigned    n;
		dir_row_t       row;
		word_t          w;
		logic [NONCE_W-1:0] win;
		logic [CODE_W-1:0]  code;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		cmd = 1'b0;
		cmd_code = '0;
		cmd_stamp = '0;
		nonce = '0;
		ack_received = 1'b0;
		cur_window = WINDOW_RESET;
		cur_none = NONE_CMD_RESET;
		last_nonce = '0;
		for (i = 0; i < HIST_DEPTH; i++)
			nonce_hist[i] = '0;
		hist_wr = 0;
		fail_cnt = '0;
		burst_left = 0;
		sender_idle = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_N; i++) begin
			row = DIR_TAB[i];
			if (row.set_cfg) begin
				drain();
				set_config(row.win, row.none_code);
			end
			pace();
			send_word(row.w, row.chk, row.r);
		end

		for (p = 0; p < PHASE_N; p++) begin
			drain();
			win = PHASE_WIN[p];
			if (win == '0)
				win = $urandom_range(2, STEP_CAP);
			if (p == 0)
				code = 8'h00;
			else if (p == 1)
				code = 8'hFF;
			else
				code = CODE_W'($urandom);
			set_config(win, code);
			for (n = 0; n < PHASE_LEN; n++) begin
				if (n == PHASE_LEN / 2)
					drain();
				pace();
				send_word(rand_word(), 1'b0, '0);
			end
		end

		// widest window, largest nonce
		drain();
		set_config(32'hFFFF_FFFF, 8'hFF);
		w = '{1'b1, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1};
		send_word(w, 1'b0, '0);
		send_word(w, 1'b0, '0);
		for (n = 0; n < 20; n++) begin
			pace();
			send_word(rand_word(), 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[nonce_anti_replay_unlock_gate.f]
hw/rtl/narug_pkg.sv
hw/rtl/narug_ram.sv
hw/rtl/narug_ctrl.sv
hw/rtl/nonce_anti_replay_unlock_gate.sv
sim/tb.sv
